// ===== design/gowg_pkg.sv =====
// Shared types and constants for the grid overlap weight generator.
// Used by gowg_ctrl, gowg_dp and grid_overlap_weight_generator.
// No dependencies.
package gowg_pkg;

  // Field widths
  localparam int unsigned IdxW     = 16;  // cell indexes
  localparam int unsigned LenW     = 32;  // Q16.16 lengths and edges
  localparam int unsigned CntOutW  = 7;   // source_count port
  localparam int unsigned CfgIdxW  = 3;   // configuration register index

  // Overlaps emitted per target cell before the list is cut
  localparam int unsigned MaxSources = 16;
  localparam int unsigned CountW     = $clog2(MaxSources + 1);

  // Datapath widths: (2n+1)*s product, its half, and the running edges
  localparam int unsigned MulAW   = IdxW + 1;
  localparam int unsigned ProdW   = MulAW + LenW;
  localparam int unsigned HalfW   = ProdW - 1;
  localparam int unsigned EdgeW   = ProdW + 1;
  localparam int unsigned DivCntW = $clog2(LenW);

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgSrcSpacing = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgTgtSpacing = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgSrcExtent  = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgTgtExtent  = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgSrcCells   = 3'd4;

  // Configuration reset values
  localparam logic [LenW-1:0] RstSpacing  = 32'h0001_0000;
  localparam logic [LenW-1:0] RstExtent   = 32'h0000_0000;
  localparam logic [IdxW-1:0] RstSrcCells = 16'd1;

  // Multiplier operand selection
  typedef enum logic [1:0] {
    MulTgt,  // (2t+1) * target_spacing
    MulSrc,  // (2f+1) * source_spacing
    MulKd    // k * source_spacing
  } mul_sel_e;

  // Controller to datapath
  typedef struct packed {
    logic     load_item;
    logic     mul_en;
    mul_sel_e mul_sel;
    logic     tgt_wb;
    logic     src_wb;
    logic     div_start;
    logic     div_step;
    logic     set_sat;
    logic     kd_wb;
    logic     lo_wb;
    logic     loop_init;
    logic     eval;
    logic     emit;
    logic     emit_null;
  } gowg_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic skip_needed;
    logic d_zero;
    logic div_last;
    logic sat;
    logic loop_enter;
    logic cont;
    logic out_free;
  } gowg_sts_t;

endpackage

// ===== design/gowg_ctrl.sv =====
// Sequencer for the grid overlap weight generator.
// Depends on gowg_pkg; drives gowg_dp through command/status structs.
module gowg_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  gowg_pkg::gowg_sts_t sts_i,
  output gowg_pkg::gowg_cmd_t cmd_o
);
  import gowg_pkg::*;

  localparam logic [3:0] SIdle  = 4'd0;
  localparam logic [3:0] STMul  = 4'd1;
  localparam logic [3:0] STWb   = 4'd2;
  localparam logic [3:0] SSWb   = 4'd3;
  localparam logic [3:0] SSkip  = 4'd4;
  localparam logic [3:0] SDiv   = 4'd5;
  localparam logic [3:0] SKMul  = 4'd6;
  localparam logic [3:0] SKWb   = 4'd7;
  localparam logic [3:0] SLMul  = 4'd8;
  localparam logic [3:0] SLWb   = 4'd9;
  localparam logic [3:0] SCheck = 4'd10;
  localparam logic [3:0] SEval  = 4'd11;
  localparam logic [3:0] SEmit  = 4'd12;
  localparam logic [3:0] SNull  = 4'd13;

  logic [3:0] state_q, state_d;

  // Next state and commands
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    cmd_o.mul_sel = MulTgt;
    in_ready_o = 1'b0;
    unique case (state_q)
      SIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load_item = 1'b1;
          state_d = STMul;
        end
      end
      STMul: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = MulTgt;
        state_d = STWb;
      end
      STWb: begin
        cmd_o.tgt_wb  = 1'b1;
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = MulSrc;
        state_d = SSWb;
      end
      SSWb: begin
        cmd_o.src_wb = 1'b1;
        state_d = SSkip;
      end
      SSkip: begin
        priority if (!sts_i.skip_needed) begin
          cmd_o.lo_wb = 1'b1;
          state_d = SCheck;
        end else if (sts_i.d_zero) begin
          cmd_o.set_sat = 1'b1;
          state_d = SNull;
        end else begin
          cmd_o.div_start = 1'b1;
          state_d = SDiv;
        end
      end
      SDiv: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_last) begin
          state_d = SKMul;
        end
      end
      SKMul: begin
        if (sts_i.sat) begin
          cmd_o.set_sat = 1'b1;
          state_d = SNull;
        end else begin
          cmd_o.mul_en  = 1'b1;
          cmd_o.mul_sel = MulKd;
          state_d = SKWb;
        end
      end
      SKWb: begin
        cmd_o.kd_wb = 1'b1;
        state_d = SLMul;
      end
      SLMul: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = MulSrc;
        state_d = SLWb;
      end
      SLWb: begin
        cmd_o.lo_wb = 1'b1;
        state_d = SCheck;
      end
      SCheck: begin
        if (sts_i.loop_enter) begin
          cmd_o.loop_init = 1'b1;
          state_d = SEval;
        end else begin
          state_d = SNull;
        end
      end
      SEval: begin
        cmd_o.eval = 1'b1;
        state_d = SEmit;
      end
      SEmit: begin
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d = sts_i.cont ? SEval : SIdle;
        end
      end
      SNull: begin
        if (sts_i.out_free) begin
          cmd_o.emit_null = 1'b1;
          state_d = SIdle;
        end
      end
      default: begin
        state_d = SIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== design/gowg_dp.sv =====
// Datapath of the grid overlap weight generator: configuration registers,
// shared multiplier, restoring divider, overlap evaluation, output register.
// Depends on gowg_pkg; commanded by gowg_ctrl.
module gowg_dp (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // configuration
  input  logic                          cfg_valid_i,
  input  logic [gowg_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [gowg_pkg::LenW-1:0]     cfg_data_i,
  // input payload
  input  logic [gowg_pkg::IdxW-1:0]     target_index_i,
  // control
  input  gowg_pkg::gowg_cmd_t           cmd_i,
  output gowg_pkg::gowg_sts_t           sts_o,
  // result channel
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [gowg_pkg::IdxW-1:0]     source_index_o,
  output logic [gowg_pkg::LenW-1:0]     weight_o,
  output logic [gowg_pkg::LenW-1:0]     target_length_o,
  output logic [gowg_pkg::IdxW-1:0]     first_source_o,
  output logic [gowg_pkg::CntOutW-1:0]  source_count_o,
  output logic                          last_o,
  output logic                          overflow_o
);
  import gowg_pkg::*;

  // Configuration
  logic [LenW-1:0] src_spc_q, tgt_spc_q, src_ext_q, tgt_ext_q;
  logic [IdxW-1:0] src_cells_q;

  // Item state
  logic [IdxW-1:0]    tgt_idx_q;
  logic [IdxW-1:0]    ptr_q;
  logic [ProdW-1:0]   prod_q;
  logic [LenW-1:0]    to_lo_q, to_hi_q;
  logic [EdgeW-1:0]   from_lo_q, from_hi_q;
  logic [LenW-1:0]    div_rem_q;
  logic [LenW-1:0]    div_quo_q;
  logic [DivCntW-1:0] div_cnt_q;
  logic [IdxW-1:0]    p_q;
  logic [CountW-1:0]  n_q;
  logic [LenW-1:0]    w_q;
  logic               cont_q, cut_q;

  // Output register
  logic               out_valid_q;
  logic [IdxW-1:0]    o_src_q, o_first_q;
  logic [LenW-1:0]    o_weight_q, o_tlen_q;
  logic [CntOutW-1:0] o_count_q;
  logic               o_last_q, o_ovf_q;

  // Configuration writes; indexes beyond the list are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_spc_q   <= RstSpacing;
      tgt_spc_q   <= RstSpacing;
      src_ext_q   <= RstExtent;
      tgt_ext_q   <= RstExtent;
      src_cells_q <= RstSrcCells;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CfgSrcSpacing: src_spc_q   <= cfg_data_i;
        CfgTgtSpacing: tgt_spc_q   <= cfg_data_i;
        CfgSrcExtent:  src_ext_q   <= cfg_data_i;
        CfgTgtExtent:  tgt_ext_q   <= cfg_data_i;
        CfgSrcCells:   src_cells_q <= cfg_data_i[IdxW-1:0];
        default: ;
      endcase
    end
  end

  // Shared multiplier, operand select
  logic [MulAW-1:0] mul_a;
  logic [LenW-1:0]  mul_b;
  logic [IdxW-1:0]  k16;
  assign k16 = div_quo_q[IdxW-1:0] + IdxW'(1);

  always_comb begin
    unique case (cmd_i.mul_sel)
      MulTgt:  begin mul_a = {tgt_idx_q, 1'b1}; mul_b = tgt_spc_q; end
      MulSrc:  begin mul_a = {ptr_q, 1'b1};     mul_b = src_spc_q; end
      MulKd:   begin mul_a = {1'b0, k16};       mul_b = src_spc_q; end
      default: begin mul_a = '0;                mul_b = '0;        end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_en) begin
      prod_q <= ProdW'(mul_a) * ProdW'(mul_b);
    end
  end

  // Half-integer edges from the product, clamped to the target extent
  logic [HalfW-1:0] half;
  logic [HalfW-1:0] tgt_lo_raw, src_lo_raw;
  logic [LenW-1:0]  half_clamp, tgt_lo_clamp;
  assign half         = prod_q[ProdW-1:1];
  assign half_clamp   = (HalfW'(tgt_ext_q) < half) ? tgt_ext_q : half[LenW-1:0];
  assign tgt_lo_raw   = (tgt_idx_q == '0) ? '0 : half - HalfW'(tgt_spc_q);
  assign tgt_lo_clamp = (HalfW'(tgt_ext_q) < tgt_lo_raw) ? tgt_ext_q
                                                          : tgt_lo_raw[LenW-1:0];
  assign src_lo_raw   = half - HalfW'(src_spc_q);

  // Restoring divider: one quotient bit per cycle
  logic [LenW:0]   div_trial, div_diff;
  logic            div_ge;
  assign div_trial = {div_rem_q, div_quo_q[LenW-1]};
  assign div_diff  = div_trial - {1'b0, src_spc_q};
  assign div_ge    = div_trial >= {1'b0, src_spc_q};

  // Pointer saturation test: f + q + 1 beyond the index range
  logic [LenW+1:0] ptr_sum;
  assign ptr_sum = (LenW+2)'(ptr_q) + (LenW+2)'(div_quo_q) + (LenW+2)'(1);

  // Overlap of the current source cell with the target cell
  logic [LenW-1:0]  src_hi_c, hi_b, w_c;
  logic [EdgeW-1:0] lo_a, nxt_lo;
  logic [IdxW:0]    p_inc;
  logic [CountW:0]  n_inc;
  logic             more_src, more_span;
  assign src_hi_c  = (EdgeW'(src_ext_q) < from_hi_q) ? src_ext_q : from_hi_q[LenW-1:0];
  assign lo_a      = (EdgeW'(to_lo_q) > from_lo_q) ? EdgeW'(to_lo_q) : from_lo_q;
  assign hi_b      = (to_hi_q < src_hi_c) ? to_hi_q : src_hi_c;
  assign w_c       = (EdgeW'(hi_b) > lo_a) ? hi_b - lo_a[LenW-1:0] : '0;
  // lower edge of cell zero is 0, not -s/2, so its successor starts at s/2
  assign nxt_lo    = (p_q == '0) ? EdgeW'(src_spc_q >> 1) : from_lo_q + EdgeW'(src_spc_q);
  assign p_inc     = (IdxW+1)'(p_q) + (IdxW+1)'(1);
  assign n_inc     = (CountW+1)'(n_q) + (CountW+1)'(1);
  assign more_src  = p_inc < (IdxW+1)'(src_cells_q);
  assign more_span = nxt_lo < EdgeW'(to_hi_q);

  // Item registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ptr_q <= '0;
    end else if (cmd_i.load_item) begin
      if (target_index_i == '0) begin
        ptr_q <= '0;
      end
    end else if (cmd_i.set_sat) begin
      ptr_q <= '1;
    end else if (cmd_i.kd_wb) begin
      ptr_q <= ptr_q + k16;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) begin
      tgt_idx_q <= target_index_i;
    end
    if (cmd_i.tgt_wb) begin
      to_hi_q <= half_clamp;
      to_lo_q <= tgt_lo_clamp;
    end
    // pointed cell upper edge
    if (cmd_i.src_wb) begin
      from_hi_q <= EdgeW'(half_clamp);
    end else if (cmd_i.kd_wb) begin
      from_hi_q <= from_hi_q + EdgeW'(prod_q);
    end else if (cmd_i.eval) begin
      from_hi_q <= from_hi_q + EdgeW'(src_spc_q);
    end
    // pointed cell lower edge
    if (cmd_i.lo_wb) begin
      from_lo_q <= (ptr_q == '0) ? '0 : EdgeW'(src_lo_raw);
    end else if (cmd_i.eval) begin
      from_lo_q <= nxt_lo;
    end
    // divider
    if (cmd_i.div_start) begin
      div_rem_q <= '0;
      div_quo_q <= to_lo_q - from_hi_q[LenW-1:0];
      div_cnt_q <= '0;
    end else if (cmd_i.div_step) begin
      div_rem_q <= div_ge ? div_diff[LenW-1:0] : div_trial[LenW-1:0];
      div_quo_q <= {div_quo_q[LenW-2:0], div_ge};
      div_cnt_q <= div_cnt_q + DivCntW'(1);
    end
    // overlap loop
    if (cmd_i.loop_init) begin
      p_q <= ptr_q;
      n_q <= '0;
    end else if (cmd_i.emit) begin
      p_q <= p_inc[IdxW-1:0];
      n_q <= n_inc[CountW-1:0];
    end
    if (cmd_i.eval) begin
      w_q    <= w_c;
      cont_q <= more_src && more_span && (n_inc < (CountW+1)'(MaxSources));
      cut_q  <= more_src && more_span && (n_inc == (CountW+1)'(MaxSources));
    end
  end

  // Output register
  logic out_free;
  assign out_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit || cmd_i.emit_null) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      o_src_q    <= p_q;
      o_weight_q <= w_q;
      o_tlen_q   <= to_hi_q - to_lo_q;
      o_first_q  <= ptr_q;
      o_count_q  <= cont_q ? '0 : CntOutW'(n_q) + CntOutW'(1);
      o_last_q   <= !cont_q;
      o_ovf_q    <= !cont_q && cut_q;
    end else if (cmd_i.emit_null) begin
      o_src_q    <= '0;
      o_weight_q <= '0;
      o_tlen_q   <= to_hi_q - to_lo_q;
      o_first_q  <= ptr_q;
      o_count_q  <= '0;
      o_last_q   <= 1'b1;
      o_ovf_q    <= 1'b0;
    end
  end

  // Status
  assign sts_o.skip_needed = EdgeW'(to_lo_q) >= from_hi_q;
  assign sts_o.d_zero      = src_spc_q == '0;
  assign sts_o.div_last    = div_cnt_q == DivCntW'(LenW - 1);
  assign sts_o.sat         = ptr_sum > (LenW+2)'({IdxW{1'b1}});
  assign sts_o.loop_enter  = (ptr_q < src_cells_q) && (from_lo_q < EdgeW'(to_hi_q));
  assign sts_o.cont        = cont_q;
  assign sts_o.out_free    = out_free;

  assign out_valid_o     = out_valid_q;
  assign source_index_o  = o_src_q;
  assign weight_o        = o_weight_q;
  assign target_length_o = o_tlen_q;
  assign first_source_o  = o_first_q;
  assign source_count_o  = o_count_q;
  assign last_o          = o_last_q;
  assign overflow_o      = o_ovf_q;

endmodule

// ===== design/grid_overlap_weight_generator.sv =====
// Top level of the grid overlap weight generator (one resampling axis).
// Depends on gowg_pkg, gowg_ctrl and gowg_dp.
//
//  Port group    Dir  Handshake               Payload
//  cfg           in   cfg_valid_i/cfg_ready_o  cfg_index_i, cfg_data_i
//  target cell   in   in_valid_i/in_ready_o    target_index_i
//  overlap       out  out_valid_o/out_ready_i  source_index_o .. overflow_o
//
//  One target cell at a time: the idle state accepts it, setup states multiply and
//  write back the cell edges and test for a skip, then each overlap result takes an
//  evaluate and an emit state, or one null state for the single empty-cell result.
//  A pointer skip adds a bit-serial division and a write-back of new pointer edges;
//  a saturating skip forms no edges. rst_ni clears the pointer and loads default
//  configuration. A stalled result register holds the sequencer until taken.
module grid_overlap_weight_generator (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [gowg_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [gowg_pkg::LenW-1:0]     cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [gowg_pkg::IdxW-1:0]     target_index_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [gowg_pkg::IdxW-1:0]     source_index_o,
  output logic [gowg_pkg::LenW-1:0]     weight_o,
  output logic [gowg_pkg::LenW-1:0]     target_length_o,
  output logic [gowg_pkg::IdxW-1:0]     first_source_o,
  output logic [gowg_pkg::CntOutW-1:0]  source_count_o,
  output logic                          last_o,
  output logic                          overflow_o
);
  import gowg_pkg::*;

  gowg_cmd_t cmd;
  gowg_sts_t sts;

  // configuration is to be written by the user only while idle (the block does not enforce it), so always take it
  assign cfg_ready_o = 1'b1;

  gowg_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  gowg_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .target_index_i  (target_index_i),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .source_index_o  (source_index_o),
    .weight_o        (weight_o),
    .target_length_o (target_length_o),
    .first_source_o  (first_source_o),
    .source_count_o  (source_count_o),
    .last_o          (last_o),
    .overflow_o      (overflow_o)
  );

endmodule

// ===== tb/grid_overlap_weight_generator_tb.sv =====
// Self-checking testbench for grid_overlap_weight_generator: directed table, then random phases.
// Results are checked against an internal overlap predictor; depends on gowg_pkg and the RTL only.
module grid_overlap_weight_generator_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import gowg_pkg::*;

  localparam int unsigned WatchdogLimit = 4000;
  localparam int unsigned HoldCycles    = 400;
  localparam int unsigned SettleCycles  = 80;
  localparam int unsigned Phases        = 6;
  localparam int unsigned ItemsPerPhase = 38;

  // One overlap result as seen on the output port group
  typedef struct packed {
    logic [IdxW-1:0]    src;
    logic [LenW-1:0]    weight;
    logic [LenW-1:0]    length;
    logic [IdxW-1:0]    first;
    logic [CntOutW-1:0] count;
    logic               last;
    logic               overflow;
  } overlap_t;

  typedef enum logic [1:0] {
    RowCfg,    // register write, block idle
    RowItem,   // target cell, checked against the predictor
    RowKnown   // target cell with a hand-written expected result
  } row_kind_e;

  typedef struct {
    row_kind_e          kind;
    logic [CfgIdxW-1:0] idx;
    logic [LenW-1:0]    data;
    overlap_t           known;
  } stim_row_t;

  logic                clk_i          = 1'b0;
  logic                rst_ni         = 1'b0;
  logic                cfg_valid_i    = 1'b0;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i    = '0;
  logic [LenW-1:0]     cfg_data_i     = '0;
  logic                in_valid_i     = 1'b0;
  logic                in_ready_o;
  logic [IdxW-1:0]     target_index_i = '0;
  logic                out_valid_o;
  logic                out_ready_i    = 1'b0;
  logic [IdxW-1:0]     source_index_o;
  logic [LenW-1:0]     weight_o;
  logic [LenW-1:0]     target_length_o;
  logic [IdxW-1:0]     first_source_o;
  logic [CntOutW-1:0]  source_count_o;
  logic                last_o;
  logic                overflow_o;

  // Predictor copy of configuration and pointer
  logic [LenW-1:0] src_spacing = RstSpacing;
  logic [LenW-1:0] tgt_spacing = RstSpacing;
  logic [LenW-1:0] src_extent  = RstExtent;
  logic [LenW-1:0] tgt_extent  = RstExtent;
  logic [IdxW-1:0] src_cells   = RstSrcCells;
  logic [IdxW-1:0] src_ptr     = '0;

  overlap_t    expected_overlaps[$];
  stim_row_t   directed_rows[$];
  int unsigned mismatches    = 0;
  int unsigned snd_idle_pct  = 0;
  int unsigned rcv_idle_pct  = 0;
  int unsigned hold_requests = 0;
  int unsigned hold_taken    = 0;
  int unsigned hold_left     = 0;
  int unsigned quiet_cycles  = 0;

  grid_overlap_weight_generator i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .target_index_i (target_index_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .source_index_o (source_index_o),
    .weight_o       (weight_o),
    .target_length_o(target_length_o),
    .first_source_o (first_source_o),
    .source_count_o (source_count_o),
    .last_o         (last_o),
    .overflow_o     (overflow_o)
  );

  always #10 clk_i = ~clk_i;

  function automatic logic [63:0] min_u64(logic [63:0] a, logic [63:0] b);
    return (a < b) ? a : b;
  endfunction

  // (n + 1/2) * s, rounded down
  function automatic logic [63:0] cell_top(logic [63:0] n, logic [63:0] s);
    return ((64'd2 * n + 64'd1) * s) >> 1;
  endfunction

  // (n - 1/2) * s, rounded down, zero for the first cell
  function automatic logic [63:0] cell_bottom(logic [63:0] n, logic [63:0] s);
    if (n == 64'd0) return 64'd0;
    return ((64'd2 * n - 64'd1) * s) >> 1;
  endfunction

  function automatic void apply_reg(logic [CfgIdxW-1:0] idx, logic [LenW-1:0] data);
    case (idx)
      CfgSrcSpacing: src_spacing = data;
      CfgTgtSpacing: tgt_spacing = data;
      CfgSrcExtent:  src_extent  = data;
      CfgTgtExtent:  tgt_extent  = data;
      CfgSrcCells:   src_cells   = data[IdxW-1:0];
      default: ;
    endcase
  endfunction

  // Works out the overlap list of one target cell; returns how many were queued
  function automatic int predict_overlaps(logic [IdxW-1:0] tgt);
    logic [63:0] t, d, lo, hi, len, f, fhi, flo, p, k, a, b, top, w;
    int          n;
    logic        cut;
    overlap_t    batch[$];
    overlap_t    r;
    t = {48'd0, tgt};
    d = {32'd0, src_spacing};
    n = 0;
    if (t == 64'd0) src_ptr = '0;

    lo  = min_u64(tgt_extent, cell_bottom(t, tgt_spacing));
    hi  = min_u64(tgt_extent, cell_top(t, tgt_spacing));
    len = hi - lo;

    // skip source cells ending at or before the target's lower edge
    f   = {48'd0, src_ptr};
    fhi = min_u64(tgt_extent, cell_top(f, d));
    if (lo >= fhi) begin
      if (d == 64'd0) begin
        f = 64'hFFFF;
      end else begin
        k = (lo - fhi) / d + 64'd1;
        if (f + k > 64'hFFFF) begin
          f = 64'hFFFF;
        end else begin
          f   = f + k;
          fhi = fhi + k * d;
        end
      end
    end
    src_ptr = f[IdxW-1:0];

    // one result per overlapping source cell, cut at MaxSources
    flo = cell_bottom(f, d);
    p   = f;
    while (p < {48'd0, src_cells} && flo < hi && n < MaxSources) begin
      top = min_u64(src_extent, fhi);
      a   = (lo > flo) ? lo : flo;
      b   = min_u64(hi, top);
      w   = (b > a) ? b - a : 64'd0;
      r   = '{p[IdxW-1:0], w[LenW-1:0], len[LenW-1:0], f[IdxW-1:0], '0, 1'b0, 1'b0};
      batch.push_back(r);
      n++;
      flo = cell_top(p, d);
      fhi = fhi + d;
      p++;
    end
    cut = (n == MaxSources) && (p < {48'd0, src_cells}) && (flo < hi);

    if (n == 0) begin
      batch.push_back('{'0, '0, len[LenW-1:0], f[IdxW-1:0], '0, 1'b1, 1'b0});
    end else begin
      r          = batch.pop_back();
      r.count    = CntOutW'(n);
      r.last     = 1'b1;
      r.overflow = cut;
      batch.push_back(r);
    end
    foreach (batch[i]) expected_overlaps.push_back(batch[i]);
    return batch.size();
  endfunction

  function automatic void report_mismatch(string what, overlap_t want, overlap_t got);
    mismatches++;
    if (mismatches <= 10) begin
      $display("%0t mismatch (%s)", $realtime, what);
      $display("  exp src=%0d w=%h len=%h first=%0d cnt=%0d last=%b ovf=%b",
               want.src, want.weight, want.length, want.first, want.count,
               want.last, want.overflow);
      $display("  got src=%0d w=%h len=%h first=%0d cnt=%0d last=%b ovf=%b",
               got.src, got.weight, got.length, got.first, got.count,
               got.last, got.overflow);
    end
  endfunction

  // Result side: check each accepted transaction, then drive ready
  always @(posedge clk_i) begin : result_side
    overlap_t got;
    overlap_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      got = '{source_index_o, weight_o, target_length_o, first_source_o,
              source_count_o, last_o, overflow_o};
      if (expected_overlaps.size() == 0) begin
        report_mismatch("no result pending", '0, got);
      end else begin
        want = expected_overlaps.pop_front();
        if (got.src !== want.src || got.weight !== want.weight ||
            got.length !== want.length || got.first !== want.first ||
            got.count !== want.count || got.last !== want.last ||
            got.overflow !== want.overflow)
          report_mismatch("field", want, got);
      end
    end
    // long hold-off on request, otherwise random stalls
    if (hold_left > 0) begin
      hold_left--;
      out_ready_i <= 1'b0;
    end else if (hold_taken != hold_requests) begin
      hold_taken++;
      hold_left = HoldCycles;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= rcv_idle_pct);
    end
  end

  // Watchdog on cycles without any transaction
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WatchdogLimit) begin
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Offer one target cell, with random gaps before it
  task automatic offer_target(input logic [IdxW-1:0] tgt);
    while ($urandom_range(99) < snd_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    target_index_i <= tgt;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [LenW-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    apply_reg(idx, data);
  endtask

  // Stop offering and wait for every outstanding result
  task automatic drain();
    in_valid_i <= 1'b0;
    while (expected_overlaps.size() != 0) @(posedge clk_i);
  endtask

  function automatic logic [LenW-1:0] random_spacing();
    case ($urandom_range(9))
      0:       return $urandom();
      1:       return $urandom_range(1, 255);
      default: return $urandom_range(32'h0000_1000, 32'h0004_0000);
    endcase
  endfunction

  // New random settings for one phase; block must be idle
  task automatic randomise_settings();
    logic [LenW-1:0] ss, ts, cells_w;
    logic [63:0]     span, tspan;
    ss      = random_spacing();
    ts      = random_spacing();
    cells_w = ($urandom_range(9) == 0) ? ($urandom() | 32'd1) : $urandom_range(1, 200);
    span    = min_u64({48'd0, cells_w[IdxW-1:0]} * ss, 64'hFFFF_FFFF);
    tspan   = min_u64(span * $urandom_range(50, 120) / 100, 64'hFFFF_FFFF);
    if ($urandom_range(6) == 0) span = $urandom();
    if ($urandom_range(6) == 0) tspan = $urandom();
    write_reg(CfgSrcSpacing, ss);
    write_reg(CfgTgtSpacing, ts);
    write_reg(CfgSrcExtent, span[LenW-1:0]);
    write_reg(CfgTgtExtent, tspan[LenW-1:0]);
    write_reg(CfgSrcCells, cells_w);
    if ($urandom_range(2) == 0)
      write_reg(CfgIdxW'($urandom_range(5, 7)), $urandom());
    cfg_valid_i <= 1'b0;
  endtask

  initial begin : stimulus
    int          added;
    int unsigned roll;
    logic [IdxW-1:0] t;

    // Directed table
    directed_rows.push_back('{RowKnown, '0, 32'd0, '{16'd0, 32'd0, 32'd0, 16'd1, 7'd0, 1'b1, 1'b0}});
    directed_rows.push_back('{RowCfg, CfgSrcExtent, 32'h0005_0000, '0});
    directed_rows.push_back('{RowCfg, CfgTgtExtent, 32'h000A_0000, '0});
    directed_rows.push_back('{RowCfg, CfgSrcCells,  32'd5,         '0});
    directed_rows.push_back('{RowKnown, '0, 32'd0,
                              '{16'd0, 32'h8000, 32'h8000, 16'd0, 7'd1, 1'b1, 1'b0}});
    directed_rows.push_back('{RowItem, '0, 32'd1, '0});
    directed_rows.push_back('{RowItem, '0, 32'd2, '0});
    directed_rows.push_back('{RowItem, '0, 32'd2, '0});        // repeated cell
    directed_rows.push_back('{RowItem, '0, 32'd7, '0});        // past source extent
    directed_rows.push_back('{RowItem, '0, 32'd20, '0});       // past target extent
    directed_rows.push_back('{RowItem, '0, 32'hFFFF, '0});     // pointer runs off
    directed_rows.push_back('{RowItem, '0, 32'd3, '0});        // descending index
    directed_rows.push_back('{RowItem, '0, 32'd0, '0});        // pointer restart
    // fine source grid under a coarse target: overlap list is cut
    directed_rows.push_back('{RowCfg, CfgSrcSpacing, 32'h0000_4000, '0});
    directed_rows.push_back('{RowCfg, CfgTgtSpacing, 32'h0008_0000, '0});
    directed_rows.push_back('{RowCfg, CfgSrcExtent,  32'h0064_0000, '0});
    directed_rows.push_back('{RowCfg, CfgTgtExtent,  32'h0064_0000, '0});
    directed_rows.push_back('{RowCfg, CfgSrcCells,   32'd1000,      '0});
    directed_rows.push_back('{RowItem, '0, 32'd0, '0});
    directed_rows.push_back('{RowItem, '0, 32'd1, '0});
    directed_rows.push_back('{RowItem, '0, 32'd2, '0});
    // zero target spacing
    directed_rows.push_back('{RowCfg, CfgTgtSpacing, 32'd0, '0});
    directed_rows.push_back('{RowItem, '0, 32'd0, '0});
    directed_rows.push_back('{RowItem, '0, 32'd5, '0});
    // zero source spacing
    directed_rows.push_back('{RowCfg, CfgTgtSpacing, 32'h0001_0000, '0});
    directed_rows.push_back('{RowCfg, CfgSrcSpacing, 32'd0, '0});
    directed_rows.push_back('{RowItem, '0, 32'd0, '0});
    directed_rows.push_back('{RowItem, '0, 32'd3, '0});
    // unused indexes are ignored, then everything at its maximum
    directed_rows.push_back('{RowCfg, 3'd5, 32'hFFFF_FFFF, '0});
    directed_rows.push_back('{RowCfg, 3'd7, 32'hFFFF_FFFF, '0});
    directed_rows.push_back('{RowCfg, CfgSrcSpacing, 32'hFFFF_FFFF, '0});
    directed_rows.push_back('{RowCfg, CfgTgtSpacing, 32'hFFFF_FFFF, '0});
    directed_rows.push_back('{RowCfg, CfgSrcExtent,  32'hFFFF_FFFF, '0});
    directed_rows.push_back('{RowCfg, CfgTgtExtent,  32'hFFFF_FFFF, '0});
    directed_rows.push_back('{RowCfg, CfgSrcCells,   32'hFFFF_FFFF, '0});
    directed_rows.push_back('{RowItem, '0, 32'd0, '0});
    directed_rows.push_back('{RowItem, '0, 32'd1, '0});
    directed_rows.push_back('{RowItem, '0, 32'h8000, '0});
    directed_rows.push_back('{RowItem, '0, 32'hFFFF, '0});
    // minimum spacings
    directed_rows.push_back('{RowCfg, CfgSrcSpacing, 32'd1, '0});
    directed_rows.push_back('{RowCfg, CfgTgtSpacing, 32'd1, '0});
    directed_rows.push_back('{RowItem, '0, 32'd0, '0});
    directed_rows.push_back('{RowItem, '0, 32'hFFFF, '0});

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i]) begin
      case (directed_rows[i].kind)
        RowCfg: begin
          drain();
          write_reg(directed_rows[i].idx, directed_rows[i].data);
        end
        default: begin
          cfg_valid_i <= 1'b0;
          offer_target(directed_rows[i].data[IdxW-1:0]);
          added = predict_overlaps(directed_rows[i].data[IdxW-1:0]);
          if (directed_rows[i].kind == RowKnown) begin
            repeat (added) void'(expected_overlaps.pop_back());
            expected_overlaps.push_back(directed_rows[i].known);
          end
        end
      endcase
    end

    // Random phases: sequences of ascending cells with restarts and noise
    for (int phase = 0; phase < Phases; phase++) begin
      snd_idle_pct = (phase < 2) ? 26 : (phase < 4) ? 62 : 0;
      rcv_idle_pct = (phase < 2) ? 62 : (phase < 4) ? 26 : 0;
      drain();
      randomise_settings();
      t = '0;
      for (int i = 0; i < ItemsPerPhase; i++) begin
        if (phase == 2 && i == 10) hold_requests++;
        if (phase == 3 && i == 20) drain();
        roll = $urandom_range(99);
        if (i == 0 || roll < 8) begin
          t = '0;
        end else if (roll < 18) begin
          t = IdxW'($urandom_range(0, 65535));
        end else if (roll < 24) begin
          if (t > 3) t = t - IdxW'($urandom_range(1, 3));
        end else begin
          t = (t > 16'hFFFD) ? 16'hFFFF : t + IdxW'($urandom_range(0, 2));
        end
        offer_target(t);
        added = predict_overlaps(t);
      end
    end

    // Wait for the tail, then let any stray result show up
    in_valid_i <= 1'b0;
    while (expected_overlaps.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
    if (mismatches == 0 && expected_overlaps.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
